/* rtl/pixel_flow_from_camera_motion_defines.svh */
//------------------------------------------------------------------------------
// Assertion macros for the pixel flow block
// Shared helpers that keep the checker's properties short and uniform.
//------------------------------------------------------------------------------
`ifndef PIXEL_FLOW_FROM_CAMERA_MOTION_DEFINES_SVH
`define PIXEL_FLOW_FROM_CAMERA_MOTION_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define PFCM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pfcm assertion failed");

// Next-cycle implication, ignored while reset is high.
`define PFCM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pfcm assertion failed");

// Next-cycle implication that is also checked across reset.
`define PFCM_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("pfcm assertion failed");

`endif

/* rtl/pfcm_pkg.sv */
//------------------------------------------------------------------------------
// pfcm_pkg
// Fixed field widths, register indexes and width helpers for the pixel flow block.
//------------------------------------------------------------------------------
package pfcm_pkg;

   localparam int VEL_W     = 21;
   localparam int DEPTH_W   = 24;
   localparam int FOCAL_W   = 16;
   localparam int CENTRE_W  = 15;
   localparam int FLOW_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam int FLOW_MAX = 32'sh7FFF_FFFF;
   localparam int FLOW_MIN = 32'sh8000_0000;

   localparam logic [FOCAL_W-1:0]  FOCAL_RESET = 16'd8000;
   localparam logic [CENTRE_W-1:0] CCOL_RESET  = 15'd5120;
   localparam logic [CENTRE_W-1:0] CROW_RESET  = 15'd3840;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FOCAL  = 2'd0,
      CSR_CCOL   = 2'd1,
      CSR_CROW   = 2'd2,
      CSR_UNUSED = 2'd3
   } csr_index_type;

   function automatic int imax(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Width of a centered coordinate in Q.4, signed.
   function automatic int calc_x_w(input int cw);
      return imax(cw + 4, CENTRE_W) + 1;
   endfunction

   // Width of f*f + x*x, signed.
   function automatic int calc_a_w(input int cw);
      return imax(2 * (FOCAL_W + 1), 2 * calc_x_w(cw)) + 1;
   endfunction

   // Width of the rotational numerator, signed.
   function automatic int calc_r_w(input int cw);
      return imax(imax(VEL_W + calc_a_w(cw), VEL_W + calc_x_w(cw) + FOCAL_W + 1),
                  VEL_W + 2 * calc_x_w(cw)) + 2;
   endfunction

   // Width of the translational numerator before scaling, signed.
   function automatic int calc_t_w(input int cw);
      return imax(FOCAL_W + 1 + VEL_W, calc_x_w(cw) + VEL_W) + 1;
   endfunction

endpackage

/* rtl/pfcm_front.sv */
//------------------------------------------------------------------------------
// pfcm_front
// Five-stage front end: centering, products, sums, velocity products and the
// dividend and divisor words for the rotational and translational quotients.
//------------------------------------------------------------------------------
module pfcm_front import pfcm_pkg::*; #(
   parameter int COORD_WIDTH   = 11,
   parameter int VEL_FRAC_BITS = 16,
   localparam int X_W  = calc_x_w(COORD_WIDTH),
   localparam int A_W  = calc_a_w(COORD_WIDTH),
   localparam int R_W  = calc_r_w(COORD_WIDTH),
   localparam int T_W  = calc_t_w(COORD_WIDTH),
   localparam int NR_W = R_W + 1,
   localparam int DR_W = FOCAL_W + VEL_FRAC_BITS - 4,
   localparam int NT_W = T_W + 21,
   localparam int DT_W = DEPTH_W + VEL_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [FOCAL_W-1:0]     focal,
   input  logic [CENTRE_W-1:0]    centre_col,
   input  logic [CENTRE_W-1:0]    centre_row,
   input  logic [COORD_WIDTH-1:0] col_pos,
   input  logic [COORD_WIDTH-1:0] row_pos,
   input  logic [DEPTH_W-1:0]     depth,
   input  logic [VEL_W-1:0]       lin_vel_x,
   input  logic [VEL_W-1:0]       lin_vel_y,
   input  logic [VEL_W-1:0]       lin_vel_z,
   input  logic [VEL_W-1:0]       ang_vel_x,
   input  logic [VEL_W-1:0]       ang_vel_y,
   input  logic [VEL_W-1:0]       ang_vel_z,
   output logic [NR_W-1:0]        ru_num,
   output logic                   ru_neg,
   output logic [NR_W-1:0]        rv_num,
   output logic                   rv_neg,
   output logic [DR_W-1:0]        r_den,
   output logic [NT_W-1:0]        tu_num,
   output logic                   tu_neg,
   output logic [NT_W-1:0]        tv_num,
   output logic                   tv_neg,
   output logic [DT_W-1:0]        t_den,
   output logic                   dzero
);

   localparam int F_W = FOCAL_W + 1;

   // Stage 1: centered coordinates and clamped focal length.
   logic signed [X_W-1:0]   xq_ff, yq_ff;
   logic signed [F_W-1:0]   fs1_ff;
   logic [DEPTH_W-1:0]      d1_ff;
   logic signed [VEL_W-1:0] vx1_ff, vy1_ff, vz1_ff, wx1_ff, wy1_ff, wz1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         xq_ff  <= $signed({{(X_W-COORD_WIDTH-4){1'b0}}, col_pos, 4'b0})
                   - $signed({{(X_W-CENTRE_W){1'b0}}, centre_col});
         yq_ff  <= $signed({{(X_W-COORD_WIDTH-4){1'b0}}, row_pos, 4'b0})
                   - $signed({{(X_W-CENTRE_W){1'b0}}, centre_row});
         fs1_ff <= (focal == '0) ? F_W'(1) : $signed({1'b0, focal});
         d1_ff  <= depth;
         vx1_ff <= $signed(lin_vel_x);
         vy1_ff <= $signed(lin_vel_y);
         vz1_ff <= $signed(lin_vel_z);
         wx1_ff <= $signed(ang_vel_x);
         wy1_ff <= $signed(ang_vel_y);
         wz1_ff <= $signed(ang_vel_z);
      end
   end

   // Stage 2: coordinate and focal products.
   logic signed [2*X_W-1:0]     xy2_ff, xx2_ff, yy2_ff;
   logic signed [2*F_W-1:0]     ff2_ff;
   logic signed [X_W+F_W-1:0]   yf2_ff, xf2_ff;
   logic signed [F_W+VEL_W-1:0] fvx2_ff, fvy2_ff;
   logic signed [X_W+VEL_W-1:0] xvz2_ff, yvz2_ff;
   logic signed [F_W-1:0]       fs2_ff;
   logic [DEPTH_W-1:0]          d2_ff;
   logic signed [VEL_W-1:0]     wx2_ff, wy2_ff, wz2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         xy2_ff  <= xq_ff * yq_ff;
         xx2_ff  <= xq_ff * xq_ff;
         yy2_ff  <= yq_ff * yq_ff;
         ff2_ff  <= fs1_ff * fs1_ff;
         yf2_ff  <= yq_ff * fs1_ff;
         xf2_ff  <= xq_ff * fs1_ff;
         fvx2_ff <= fs1_ff * vx1_ff;
         fvy2_ff <= fs1_ff * vy1_ff;
         xvz2_ff <= xq_ff * vz1_ff;
         yvz2_ff <= yq_ff * vz1_ff;
         fs2_ff  <= fs1_ff;
         d2_ff   <= d1_ff;
         wx2_ff  <= wx1_ff;
         wy2_ff  <= wy1_ff;
         wz2_ff  <= wz1_ff;
      end
   end

   // Stage 3: sums feeding the angular products and the translational numerators.
   logic signed [A_W-1:0]       a3_ff, b3_ff;
   logic signed [T_W-1:0]       tu3_ff, tv3_ff;
   logic signed [2*X_W-1:0]     xy3_ff;
   logic signed [X_W+F_W-1:0]   yf3_ff, xf3_ff;
   logic signed [F_W-1:0]       fs3_ff;
   logic [DEPTH_W-1:0]          d3_ff;
   logic signed [VEL_W-1:0]     wx3_ff, wy3_ff, wz3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a3_ff  <= A_W'(ff2_ff) + A_W'(xx2_ff);
         b3_ff  <= A_W'(ff2_ff) + A_W'(yy2_ff);
         tu3_ff <= T_W'(xvz2_ff) - T_W'(fvx2_ff);
         tv3_ff <= T_W'(yvz2_ff) - T_W'(fvy2_ff);
         xy3_ff <= xy2_ff;
         yf3_ff <= yf2_ff;
         xf3_ff <= xf2_ff;
         fs3_ff <= fs2_ff;
         d3_ff  <= d2_ff;
         wx3_ff <= wx2_ff;
         wy3_ff <= wy2_ff;
         wz3_ff <= wz2_ff;
      end
   end

   // Stage 4: angular velocity products.
   logic signed [VEL_W+2*X_W-1:0]   p1_ff, q2_ff;
   logic signed [VEL_W+A_W-1:0]     p2_ff, q1_ff;
   logic signed [VEL_W+X_W+F_W-1:0] p3_ff, q3_ff;
   logic signed [T_W-1:0]           tu4_ff, tv4_ff;
   logic signed [F_W-1:0]           fs4_ff;
   logic [DEPTH_W-1:0]              d4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff  <= wx3_ff * xy3_ff;
         p2_ff  <= wy3_ff * a3_ff;
         p3_ff  <= wz3_ff * yf3_ff;
         q1_ff  <= wx3_ff * b3_ff;
         q2_ff  <= wy3_ff * xy3_ff;
         q3_ff  <= wz3_ff * xf3_ff;
         tu4_ff <= tu3_ff;
         tv4_ff <= tv3_ff;
         fs4_ff <= fs3_ff;
         d4_ff  <= d3_ff;
      end
   end

   // Stage 5: signed numerators become magnitudes plus half a divisor, so the
   // dividers round to nearest with ties away from zero.
   logic signed [R_W-1:0] ru_s, rv_s;
   logic [R_W-1:0]        ru_mag, rv_mag;
   logic [T_W-1:0]        tu_mag, tv_mag;
   logic [NR_W-1:0]       r_half;
   logic [NT_W-1:0]       t_half;

   always_comb begin
      ru_s   = R_W'(p1_ff) - R_W'(p2_ff) + R_W'(p3_ff);
      rv_s   = R_W'(q1_ff) - R_W'(q2_ff) - R_W'(q3_ff);
      ru_mag = ru_s[R_W-1] ? R_W'(-ru_s) : R_W'(ru_s);
      rv_mag = rv_s[R_W-1] ? R_W'(-rv_s) : R_W'(rv_s);
      tu_mag = tu4_ff[T_W-1] ? T_W'(-tu4_ff) : T_W'(tu4_ff);
      tv_mag = tv4_ff[T_W-1] ? T_W'(-tv4_ff) : T_W'(tv4_ff);
      r_half = NR_W'(fs4_ff[FOCAL_W-1:0]) << (VEL_FRAC_BITS - 5);
      t_half = NT_W'(d4_ff) << (VEL_FRAC_BITS - 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ru_num <= NR_W'(ru_mag) + r_half;
         rv_num <= NR_W'(rv_mag) + r_half;
         ru_neg <= ru_s[R_W-1];
         rv_neg <= rv_s[R_W-1];
         r_den  <= DR_W'(fs4_ff[FOCAL_W-1:0]) << (VEL_FRAC_BITS - 4);
         tu_num <= (NT_W'(tu_mag) << 20) + t_half;
         tv_num <= (NT_W'(tv_mag) << 20) + t_half;
         tu_neg <= tu4_ff[T_W-1];
         tv_neg <= tv4_ff[T_W-1];
         t_den  <= DT_W'(d4_ff) << VEL_FRAC_BITS;
         dzero  <= (d4_ff == '0);
      end
   end

endmodule

/* rtl/pfcm_div.sv */
//------------------------------------------------------------------------------
// pfcm_div
// Pipelined restoring divider, one quotient bit per register stage, with a
// sideband word that travels alongside each operand pair.
//------------------------------------------------------------------------------
module pfcm_div import pfcm_pkg::*; #(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 16,
   parameter int QUO_W  = 16,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic [QUO_W-1:0]  quo,
   output logic [SIDE_W-1:0] side_out
);

   localparam int CMP_W = imax(NUM_W, DEN_W + QUO_W) + 1;

   logic [NUM_W-1:0]  rem_w  [QUO_W+1];
   logic [DEN_W-1:0]  den_w  [QUO_W+1];
   logic [QUO_W-1:0]  quo_w  [QUO_W+1];
   logic [SIDE_W-1:0] side_w [QUO_W+1];

   assign rem_w[0]  = num;
   assign den_w[0]  = den;
   assign quo_w[0]  = '0;
   assign side_w[0] = side_in;

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int BIT = QUO_W - 1 - k;

      logic [CMP_W-1:0]  rem_x, sub_x;
      logic              take;
      logic [NUM_W-1:0]  rem_in, rem_ff;
      logic [QUO_W-1:0]  quo_in, quo_ff;
      logic [DEN_W-1:0]  den_ff;
      logic [SIDE_W-1:0] side_ff;

      always_comb begin
         rem_x  = CMP_W'(rem_w[k]);
         sub_x  = CMP_W'(den_w[k]) << BIT;
         take   = (rem_x >= sub_x);
         rem_in = take ? NUM_W'(rem_x - sub_x) : rem_w[k];
         quo_in = {quo_w[k][QUO_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            quo_ff  <= quo_in;
            den_ff  <= den_w[k];
            side_ff <= side_w[k];
         end
      end

      assign rem_w[k+1]  = rem_ff;
      assign quo_w[k+1]  = quo_ff;
      assign den_w[k+1]  = den_ff;
      assign side_w[k+1] = side_ff;
   end

   assign quo      = quo_w[QUO_W];
   assign side_out = side_w[QUO_W];

endmodule

/* rtl/pixel_flow_from_camera_motion.sv */
// Pipeline: front end, dividers, sign stage and output register; Q is the
// quotient width of the bit-per-stage dividers (47 at the default parameters).
// Throughput: one word per cycle; the whole pipeline advances whenever the output
// register is empty or being taken, so the restoring dividers set the depth.
// Reset: synchronous, active high; clears the valid bits and loads focal length 8000,
// principal point column 5120 and row 3840.
//------------------------------------------------------------------------------
// pixel_flow_from_camera_motion
// Image-plane flow at a pixel induced by 6-DoF camera velocity, using the
// point-feature interaction matrix, in fixed point with saturation.
//------------------------------------------------------------------------------
module pixel_flow_from_camera_motion import pfcm_pkg::*; #(
   parameter int COORD_WIDTH   = 11,
   parameter int VEL_FRAC_BITS = 16,
   localparam int REQ_BITS = 2 * COORD_WIDTH + DEPTH_W + 6 * VEL_W,
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // col_pos, row_pos, depth, lin_vel_x/y/z, ang_vel_x/y/z, zero pad
   input  logic [REQ_W-1:0]     req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // flow_col, flow_row
   output logic [2*FLOW_W-1:0]  rsp_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   localparam int R_W   = calc_r_w(COORD_WIDTH);
   localparam int T_W   = calc_t_w(COORD_WIDTH);
   localparam int NR_W  = R_W + 1;
   localparam int DR_W  = FOCAL_W + VEL_FRAC_BITS - 4;
   localparam int NT_W  = T_W + 21;
   localparam int DT_W  = DEPTH_W + VEL_FRAC_BITS;
   localparam int QW    = imax(NR_W - VEL_FRAC_BITS + 4, NT_W - VEL_FRAC_BITS);
   localparam int S_W   = QW + 2;
   localparam int PIPE_N = 5 + QW + 2;

   localparam int O_ROW = COORD_WIDTH;
   localparam int O_DEP = 2 * COORD_WIDTH;
   localparam int O_VX  = O_DEP + DEPTH_W;
   localparam int O_VY  = O_VX + VEL_W;
   localparam int O_VZ  = O_VY + VEL_W;
   localparam int O_WX  = O_VZ + VEL_W;
   localparam int O_WY  = O_WX + VEL_W;
   localparam int O_WZ  = O_WY + VEL_W;

   // Configuration registers.
   logic [FOCAL_W-1:0]  focal_ff;
   logic [CENTRE_W-1:0] ccol_ff, crow_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= FOCAL_RESET;
         ccol_ff  <= CCOL_RESET;
         crow_ff  <= CROW_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_FOCAL: focal_ff <= csr_data;
            CSR_CCOL:  ccol_ff  <= csr_data[CENTRE_W-1:0];
            CSR_CROW:  crow_ff  <= csr_data[CENTRE_W-1:0];
            default: ;
         endcase
      end
   end

   // Global advance: every stage moves together unless the result word is held.
   logic              en;
   logic [PIPE_N-1:0] valid_ff, valid_in;

   assign en         = !valid_ff[PIPE_N-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = valid_ff[PIPE_N-1];

   always_comb begin
      valid_in = {valid_ff[PIPE_N-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   logic [NR_W-1:0] ru_num, rv_num;
   logic [NT_W-1:0] tu_num, tv_num;
   logic [DR_W-1:0] r_den;
   logic [DT_W-1:0] t_den;
   logic            ru_neg, rv_neg, tu_neg, tv_neg, dzero;

   pfcm_front #(
      .COORD_WIDTH   (COORD_WIDTH),
      .VEL_FRAC_BITS (VEL_FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .en         (en),
      .focal      (focal_ff),
      .centre_col (ccol_ff),
      .centre_row (crow_ff),
      .col_pos    (req_tdata[COORD_WIDTH-1:0]),
      .row_pos    (req_tdata[O_ROW +: COORD_WIDTH]),
      .depth      (req_tdata[O_DEP +: DEPTH_W]),
      .lin_vel_x  (req_tdata[O_VX +: VEL_W]),
      .lin_vel_y  (req_tdata[O_VY +: VEL_W]),
      .lin_vel_z  (req_tdata[O_VZ +: VEL_W]),
      .ang_vel_x  (req_tdata[O_WX +: VEL_W]),
      .ang_vel_y  (req_tdata[O_WY +: VEL_W]),
      .ang_vel_z  (req_tdata[O_WZ +: VEL_W]),
      .ru_num     (ru_num),
      .ru_neg     (ru_neg),
      .rv_num     (rv_num),
      .rv_neg     (rv_neg),
      .r_den      (r_den),
      .tu_num     (tu_num),
      .tu_neg     (tu_neg),
      .tv_num     (tv_num),
      .tv_neg     (tv_neg),
      .t_den      (t_den),
      .dzero      (dzero)
   );

   logic [QW-1:0] qru, qrv, qtu, qtv;
   logic          sru, srv, stv;
   logic [1:0]    side_tu;

   pfcm_div #(.NUM_W(NR_W), .DEN_W(DR_W), .QUO_W(QW), .SIDE_W(1)) u_div_ru (
      .clock (clock), .en (en), .num (ru_num), .den (r_den),
      .side_in (ru_neg), .quo (qru), .side_out (sru)
   );

   pfcm_div #(.NUM_W(NR_W), .DEN_W(DR_W), .QUO_W(QW), .SIDE_W(1)) u_div_rv (
      .clock (clock), .en (en), .num (rv_num), .den (r_den),
      .side_in (rv_neg), .quo (qrv), .side_out (srv)
   );

   pfcm_div #(.NUM_W(NT_W), .DEN_W(DT_W), .QUO_W(QW), .SIDE_W(2)) u_div_tu (
      .clock (clock), .en (en), .num (tu_num), .den (t_den),
      .side_in ({dzero, tu_neg}), .quo (qtu), .side_out (side_tu)
   );

   pfcm_div #(.NUM_W(NT_W), .DEN_W(DT_W), .QUO_W(QW), .SIDE_W(1)) u_div_tv (
      .clock (clock), .en (en), .num (tv_num), .den (t_den),
      .side_in (tv_neg), .quo (qtv), .side_out (stv)
   );

   // Signs applied; with unknown depth the translational part drops out.
   logic signed [QW:0] fu_r_ff, fv_r_ff, fu_t_ff, fv_t_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         fu_r_ff <= sru ? -$signed({1'b0, qru}) : $signed({1'b0, qru});
         fv_r_ff <= srv ? -$signed({1'b0, qrv}) : $signed({1'b0, qrv});
         if (side_tu[1]) begin
            fu_t_ff <= '0;
            fv_t_ff <= '0;
         end else begin
            fu_t_ff <= side_tu[0] ? -$signed({1'b0, qtu}) : $signed({1'b0, qtu});
            fv_t_ff <= stv ? -$signed({1'b0, qtv}) : $signed({1'b0, qtv});
         end
      end
   end

   localparam logic signed [S_W-1:0] LIM_HI = S_W'(FLOW_MAX);
   localparam logic signed [S_W-1:0] LIM_LO = S_W'(FLOW_MIN);

   logic signed [S_W-1:0]  sum_u, sum_v;
   logic [FLOW_W-1:0]      col_sat, row_sat;
   logic [2*FLOW_W-1:0]    out_ff;

   always_comb begin
      sum_u = S_W'(fu_r_ff) + S_W'(fu_t_ff);
      sum_v = S_W'(fv_r_ff) + S_W'(fv_t_ff);
      if (sum_u > LIM_HI)      col_sat = FLOW_W'(LIM_HI);
      else if (sum_u < LIM_LO) col_sat = FLOW_W'(LIM_LO);
      else                     col_sat = FLOW_W'(sum_u);
      if (sum_v > LIM_HI)      row_sat = FLOW_W'(LIM_HI);
      else if (sum_v < LIM_LO) row_sat = FLOW_W'(LIM_LO);
      else                     row_sat = FLOW_W'(sum_v);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= {row_sat, col_sat};
      end
   end

   assign rsp_tdata = out_ff;

endmodule

/* rtl/pfcm_checker.sv */
//------------------------------------------------------------------------------
// pfcm_checker
// Port-level checks on the pixel flow block, attached by bind.
//------------------------------------------------------------------------------
`include "pixel_flow_from_camera_motion_defines.svh"

module pfcm_port_checker import pfcm_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [2*FLOW_W-1:0] rsp_tdata,
   input logic                csr_ready
);

   // A held result word keeps its value until it is taken.
   `PFCM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // The input side stalls exactly when a result word is blocked.
   `PFCM_ASSERT_NOW(a_req_stall, 1'b1, req_tready == (!rsp_tvalid || rsp_tready))

   // No result word right after reset.
   `PFCM_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_tvalid)

   // Register writes are never refused.
   `PFCM_ASSERT_NOW(a_csr_ready, 1'b1, csr_ready)

endmodule

bind pixel_flow_from_camera_motion pfcm_port_checker u_pfcm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);

/* test/pfcm_checker.sv */
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Pixel flow checker
// Watches the request, result and register channels of the pixel flow block.
// It keeps its own copy of the registers, predicts the flow for each accepted
// word and compares every result word against the oldest prediction.
//------------------------------------------------------------------------------
module pfcm_checker import pfcm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [175:0]         req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [2*FLOW_W-1:0]  rsp_tdata,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output int                   errors,
   output int                   pending
);

   typedef struct packed {
      logic [FLOW_W-1:0] flow_col;
      logic [FLOW_W-1:0] flow_row;
   } flow_type;

   flow_type              flow_queue[$];
   logic [FOCAL_W-1:0]    focal;
   logic [CENTRE_W-1:0]   ccol;
   logic [CENTRE_W-1:0]   crow;

   // Division rounded to nearest, ties away from zero.
   function automatic longint round_div(input longint num, input longint unsigned den);
      longint unsigned mag;
      longint unsigned q;
      mag = (num < 0) ? longint'(0) - num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [FLOW_W-1:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic flow_type calc_flow(input logic [175:0] w);
      longint fq, xq, yq, vx, vy, vz, wx, wy, wz, xy, ru, rv, fu, fv, tu, tv;
      longint unsigned dq, rden, tden;
      flow_type r;
      fq = (focal == 0) ? 1 : longint'(focal);
      xq = longint'(w[10:0]) * 16 - longint'(ccol);
      yq = longint'(w[21:11]) * 16 - longint'(crow);
      dq = w[45:22];
      vx = longint'($signed(w[66:46]));
      vy = longint'($signed(w[87:67]));
      vz = longint'($signed(w[108:88]));
      wx = longint'($signed(w[129:109]));
      wy = longint'($signed(w[150:130]));
      wz = longint'($signed(w[171:151]));
      rden = longint'(fq) << 12;
      xy = xq * yq;
      ru = wx * xy - wy * (fq * fq + xq * xq) + wz * yq * fq;
      rv = wx * (fq * fq + yq * yq) - wy * xy - wz * xq * fq;
      fu = round_div(ru, rden);
      fv = round_div(rv, rden);
      // Unknown depth leaves out the translational terms.
      if (dq != 0) begin
         tden = dq << 16;
         tu = (-fq * vx + xq * vz) * (longint'(1) << 20);
         tv = (-fq * vy + yq * vz) * (longint'(1) << 20);
         fu += round_div(tu, tden);
         fv += round_div(tv, tden);
      end
      r.flow_col = clamp32(fu);
      r.flow_row = clamp32(fv);
      return r;
   endfunction

   always @(posedge clock) begin
      flow_type exp_flow;
      int       delta;
      int       err_n;
      if (reset) begin
         focal   <= FOCAL_RESET;
         ccol    <= CCOL_RESET;
         crow    <= CROW_RESET;
         flow_queue.delete();
         errors  <= 0;
         pending <= 0;
      end else begin
         delta = 0;
         err_n = 0;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_FOCAL: focal <= csr_data;
               CSR_CCOL:  ccol  <= csr_data[CENTRE_W-1:0];
               CSR_CROW:  crow  <= csr_data[CENTRE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (flow_queue.size() == 0) begin
               $error("result word with no prediction waiting: %h", rsp_tdata);
               err_n += 1;
            end else begin
               exp_flow = flow_queue.pop_front();
               delta -= 1;
               if (rsp_tdata[31:0] !== exp_flow.flow_col) begin
                  $error("flow_col mismatch: expected %0d, got %0d",
                         $signed(exp_flow.flow_col), $signed(rsp_tdata[31:0]));
                  err_n += 1;
               end
               if (rsp_tdata[63:32] !== exp_flow.flow_row) begin
                  $error("flow_row mismatch: expected %0d, got %0d",
                         $signed(exp_flow.flow_row), $signed(rsp_tdata[63:32]));
                  err_n += 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            flow_queue.push_back(calc_flow(req_tdata));
            delta += 1;
         end
         errors  <= errors + err_n;
         pending <= pending + delta;
      end
   end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Pixel flow testbench
// Drives directed and random pixel words through several register settings,
// with random gaps and stalls on both sides and one long result stall, and
// reports the verdict from the checker's error count.
//------------------------------------------------------------------------------
module tb;
   import pfcm_pkg::*;

   localparam int NUM_PHASES = 6;
   localparam int PHASE_WORDS = 190;
   localparam int DRAIN_CYCLES = 80;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [175:0]         req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [2*FLOW_W-1:0]  rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FOCAL;
   logic [CSR_DAT_W-1:0] csr_data = '0;
   int                   errors;
   int                   pending;
   int                   idle_cycles = 0;
   bit                   burst_mode = 1'b0;

   always #4 clock = ~clock;

   pixel_flow_from_camera_motion i_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   pfcm_checker i_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .errors, .pending
   );

   // Ends the run when no channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("pixel_flow_from_camera_motion verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [20:0] pick_vel();
      case ($urandom_range(0, 5))
         0: return 21'h100000;
         1: return 21'h0FFFFF;
         2: return 21'($signed(9'($urandom)));
         default: return 21'($urandom);
      endcase
   endfunction

   function automatic logic [175:0] rand_word();
      logic [23:0] depth;
      case ($urandom_range(0, 5))
         0: depth = '0;
         1: depth = 24'($urandom_range(1, 64));
         2: depth = 24'hFFFFFF;
         default: depth = 24'($urandom);
      endcase
      return {4'b0, pick_vel(), pick_vel(), pick_vel(), pick_vel(), pick_vel(),
              pick_vel(), depth, 11'($urandom), 11'($urandom)};
   endfunction

   function automatic logic [175:0] make_word(input logic [10:0] col, input logic [10:0] row,
                                              input logic [23:0] depth,
                                              input logic [20:0] vel);
      return {4'b0, vel, vel, vel, vel, vel, vel, depth, row, col};
   endfunction

   // A word stays valid across back-to-back sends; it drops only for a gap.
   task automatic send_word(input logic [175:0] w);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DAT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result side: random stalls per word, one long hold-off partway through.
   initial begin
      int stall;
      int taken;
      taken = 0;
      @(negedge reset);
      forever begin
         stall = burst_mode ? 0 : $urandom_range(0, 19);
         if (taken == 300) stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   initial begin
      logic [15:0] focal_set[NUM_PHASES];
      logic [15:0] ccol_set[NUM_PHASES];
      logic [15:0] crow_set[NUM_PHASES];
      focal_set = '{16, 65535, 0, 16'($urandom_range(16, 65535)), 1000, 8000};
      ccol_set  = '{0, 32767, 16383, 16'($urandom_range(0, 32767)), 32767, 5120};
      crow_set  = '{0, 32767, 100, 16'($urandom_range(0, 32767)), 0, 3840};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset settings: corners, depth cases, velocity extremes.
      send_word('0);
      send_word(make_word(11'd0, 11'd0, 24'd0, 21'h100000));
      send_word(make_word(11'd2047, 11'd2047, 24'd0, 21'h0FFFFF));
      send_word(make_word(11'd2047, 11'd0, 24'd1, 21'h100000));
      send_word(make_word(11'd0, 11'd2047, 24'd1, 21'h0FFFFF));
      send_word(make_word(11'd320, 11'd240, 24'hFFFFFF, 21'h0FFFFF));
      send_word(make_word(11'd320, 11'd240, 24'h010000, 21'h010000));
      send_word(make_word(11'd2047, 11'd2047, 24'hFFFFFF, 21'h100000));
      send_word(make_word(11'd1, 11'd1, 24'd3, 21'h1FFFFF));
      send_word({4'b0, 21'h0, 21'h0, 21'h010000, 21'h0, 21'h0, 21'h0, 24'h010000,
                 11'd100, 11'd700});
      send_word({4'b0, 21'h0, 21'h010000, 21'h0, 21'h0, 21'h0, 21'h0, 24'h0,
                 11'd700, 11'd100});
      send_word({4'b0, 21'h010000, 21'h0, 21'h0, 21'h0, 21'h0, 21'h0, 24'h0,
                 11'd0, 11'd2047});
      send_word({4'b0, 21'h0, 21'h0, 21'h0, 21'h100000, 21'h0FFFFF, 21'h100000,
                 24'd1, 11'd2047, 11'd0});
      send_word({4'b0, 21'h0FFFFF, 21'h100000, 21'h0FFFFF, 21'h0, 21'h0, 21'h0,
                 24'h0, 11'd0, 11'd0});
      send_word({4'b0, 126'h0, 24'h0, 11'h555, 11'h2AA});
      send_word({4'b0, {6{21'h0AAAAA}}, 24'hAAAAAA, 11'h2AA, 11'h555});
      send_word({4'b0, {6{21'h155555}}, 24'h555555, 11'h555, 11'h2AA});

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         write_reg(CSR_FOCAL, focal_set[p]);
         write_reg(CSR_CCOL, ccol_set[p]);
         write_reg(CSR_CROW, crow_set[p]);
         csr_valid <= 1'b0;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            send_word(rand_word());
         end
      end
      burst_mode = 1'b0;
      wait_idle();

      if (errors == 0) begin
         $display("pixel_flow_from_camera_motion verification clean");
      end else begin
         $display("pixel_flow_from_camera_motion verification failed");
      end
      $finish;
   end

endmodule
